// ===== hw/rtl/csvfs_pkg.sv =====
// Shared types and constants for the CSV line field splitter.
package csvfs_pkg;

	localparam logic [7:0] QUOTE_BYTE = 8'd34;
	localparam logic [7:0] SEP_RESET  = 8'd44;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       field_end;
		logic       line_end;
		logic       quote_error;
	} res_item_t;

endpackage

// ===== hw/rtl/csv_line_field_splitter.sv =====
// Top level of the CSV line field splitter.
// Splits a CSV line, one byte per transfer with tlast on the line's final byte, into field
// content bytes and field/line markers. Quotes toggle quoting and are dropped, a doubled quote
// inside a quoted field yields one literal quote, the separator (cfg register, reset ',') ends
// a field only outside quotes, and control bytes are dropped. Each input byte gives zero or one
// result; the final byte always gives one with field_end and line_end set, and quote_error set
// if the line ended inside quotes. One byte is accepted every cycle while the output does not
// stall. A result passes the input register, then the result register, on its way to the output.
// While the output stalls, up to three result-bearing bytes are held (two in the result buffer,
// one in the input register) before s_tready drops.
// Write the separator only while the block is idle.
module csv_line_field_splitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // line_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [2:0] m_tuser,   // [0] byte_valid, [1] field_end, [2] quote_error
	output logic       m_tlast    // line_end
);

	csvfs_pkg::in_item_t  in_item;
	csvfs_pkg::in_item_t  s1_item;
	csvfs_pkg::res_item_t res_item;
	csvfs_pkg::res_item_t out_item;
	logic                 s1_valid;
	logic                 s1_take;
	logic                 res_valid;
	logic                 res_ready;

	assign in_item.in_byte   = s_tdata;
	assign in_item.line_last = s_tlast;

	csvfs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.s1_valid (s1_valid),
		.s1_take  (s1_take),
		.s1_item  (s1_item)
	);

	csvfs_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s1_valid  (s1_valid),
		.s1_item   (s1_item),
		.res_ready (res_ready),
		.s1_take   (s1_take),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	csvfs_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = out_item.out_byte;
	assign m_tuser = {out_item.quote_error, out_item.field_end, out_item.byte_valid};
	assign m_tlast = out_item.line_end;

endmodule

// ===== hw/rtl/csvfs_in_stage.sv =====
// Input register stage: holds one accepted byte until the parser takes it.
module csvfs_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  csvfs_pkg::in_item_t in_item,
	output logic                s1_valid,
	input  logic                s1_take,
	output csvfs_pkg::in_item_t s1_item
);

	logic                valid_s1;
	csvfs_pkg::in_item_t item_s1;

	assign in_ready = !valid_s1 || s1_take;
	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hw/rtl/csvfs_parse.sv =====
// Parser: quote state, separator register and per-byte result decode.
module csvfs_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	input  logic                 s1_valid,
	input  csvfs_pkg::in_item_t  s1_item,
	input  logic                 res_ready,
	output logic                 s1_take,
	output logic                 res_valid,
	output csvfs_pkg::res_item_t res_item
);

	logic [7:0] separator_q;
	logic       inside_q;
	logic       just_closed_q;

	logic [7:0] b;
	logic       is_quote;
	logic       is_ctrl;
	logic       nx_inside;
	logic       nx_closed;
	logic       emit;
	logic       keep;
	logic       sep_hit;
	logic [7:0] ob;
	logic       err;

	assign b        = s1_item.in_byte;
	assign is_quote = (b == csvfs_pkg::QUOTE_BYTE);
	assign is_ctrl  = b inside {[8'd0:8'd31], 8'd127};

	always_comb begin
		nx_inside = inside_q;
		nx_closed = 1'b0;
		keep      = 1'b0;
		sep_hit   = 1'b0;
		ob        = 8'd0;
		if (is_quote) begin
			if (inside_q) begin
				nx_inside = 1'b0;
				nx_closed = 1'b1;
			end else if (just_closed_q) begin
				// doubled quote: literal quote, section reopens
				nx_inside = 1'b1;
				keep      = 1'b1;
				ob        = csvfs_pkg::QUOTE_BYTE;
			end else begin
				nx_inside = 1'b1;
			end
		end else if (b == separator_q && !inside_q) begin
			sep_hit = 1'b1;
		end else if (!is_ctrl) begin
			keep = 1'b1;
			ob   = b;
		end
	end

	assign err  = s1_item.line_last && nx_inside;
	assign emit = keep || sep_hit || s1_item.line_last;

	always_comb begin
		res_item.out_byte    = err ? 8'd0 : ob;
		res_item.byte_valid  = keep && !err;
		res_item.field_end   = sep_hit || s1_item.line_last;
		res_item.line_end    = s1_item.line_last;
		res_item.quote_error = err;
	end

	assign s1_take   = s1_valid && (!emit || res_ready);
	assign res_valid = s1_valid && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q   <= csvfs_pkg::SEP_RESET;
			inside_q      <= 1'b0;
			just_closed_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				separator_q <= cfg_wdata;
			end
			if (s1_take) begin
				inside_q      <= nx_inside && !s1_item.line_last;
				just_closed_q <= nx_closed && !s1_item.line_last;
			end
		end
	end

endmodule

// ===== hw/rtl/csvfs_out_buf.sv =====
// Two-entry result buffer; upstream ready comes from a register only.
module csvfs_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	output logic                 res_ready,
	input  csvfs_pkg::res_item_t res_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output csvfs_pkg::res_item_t out_item
);

	logic                 main_valid_q;
	logic                 skid_valid_q;
	csvfs_pkg::res_item_t main_q;
	csvfs_pkg::res_item_t skid_q;
	logic                 push;
	logic                 pop;

	assign res_ready = !skid_valid_q;
	assign push      = res_valid && res_ready;
	assign pop       = main_valid_q && out_ready;
	assign out_valid = main_valid_q;
	assign out_item  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end else if (push && (pop || !main_valid_q)) begin
			main_q <= res_item;
		end else if (push) begin
			skid_q <= res_item;
		end
	end

endmodule

// ===== bench/csv_split_checker.sv =====
// Checker for the CSV line field splitter: predicts results from input transfers and compares.
module csv_split_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // line_last
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic [2:0] m_tuser,   // [0] byte_valid, [1] field_end, [2] quote_error
	input  logic       m_tlast,   // line_end
	output int         fail_count,
	output int         pending,
	output int         results_seen,
	output int         lines_seen,
	output int         quote_errors_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
	localparam logic [7:0] DEL_BYTE        = 8'd127;

	logic [7:0]           sep_copy = csvfs_pkg::SEP_RESET;
	bit                   in_quotes;
	bit                   quote_closed;
	csvfs_pkg::res_item_t field_q[$];
	csvfs_pkg::res_item_t got_res;
	csvfs_pkg::res_item_t want_res;
	int                   fails;
	int                   n_results;
	int                   n_lines;
	int                   n_qerr;

	assign fail_count        = fails;
	assign results_seen      = n_results;
	assign lines_seen        = n_lines;
	assign quote_errors_seen = n_qerr;

	// Advances the quote state by one byte; returns 1 when the byte yields a result.
	function automatic bit split_byte(input logic [7:0] b, input logic last,
			output csvfs_pkg::res_item_t r);
		bit         emit;
		bit         keep;
		bit         fend;
		bit         err;
		logic [7:0] ob;
		emit = 1'b0;
		keep = 1'b0;
		fend = 1'b0;
		ob   = 8'd0;
		if (b == csvfs_pkg::QUOTE_BYTE) begin
			if (in_quotes) begin
				in_quotes    = 1'b0;
				quote_closed = 1'b1;
			end else if (quote_closed) begin
				// doubled quote: literal quote, section reopens
				quote_closed = 1'b0;
				in_quotes    = 1'b1;
				emit         = 1'b1;
				keep         = 1'b1;
				ob           = csvfs_pkg::QUOTE_BYTE;
			end else begin
				in_quotes = 1'b1;
			end
		end else begin
			quote_closed = 1'b0;
			if (b == sep_copy && !in_quotes) begin
				emit = 1'b1;
				fend = 1'b1;
			end else if (b >= FIRST_PRINTABLE && b != DEL_BYTE) begin
				emit = 1'b1;
				keep = 1'b1;
				ob   = b;
			end
		end
		if (last) begin
			err          = in_quotes;
			in_quotes    = 1'b0;
			quote_closed = 1'b0;
			r.out_byte    = err ? 8'd0 : ob;
			r.byte_valid  = !err && keep;
			r.field_end   = 1'b1;
			r.line_end    = 1'b1;
			r.quote_error = err;
			return 1'b1;
		end
		r.out_byte    = ob;
		r.byte_valid  = keep;
		r.field_end   = fend;
		r.line_end    = 1'b0;
		r.quote_error = 1'b0;
		return emit;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			fails++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_copy     = csvfs_pkg::SEP_RESET;
			in_quotes    = 1'b0;
			quote_closed = 1'b0;
			field_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				sep_copy = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (split_byte(s_tdata, s_tlast, got_res))
					field_q.insert(field_q.size(), got_res);
			end
			if (m_tvalid && m_tready) begin
				n_results++;
				if (field_q.size() == 0) begin
					fails++;
					$error("unexpected result transfer: out_byte %0d user %0d line_end %0d",
						m_tdata, m_tuser, m_tlast);
				end else begin
					want_res = field_q.pop_front();
					check_field("out_byte", want_res.out_byte, m_tdata);
					check_field("byte_valid", want_res.byte_valid, m_tuser[0]);
					check_field("field_end", want_res.field_end, m_tuser[1]);
					check_field("quote_error", want_res.quote_error, m_tuser[2]);
					check_field("line_end", want_res.line_end, m_tlast);
					if (m_tlast === 1'b1)
						n_lines++;
					if (m_tuser[2] === 1'b1)
						n_qerr++;
				end
			end
			pending <= field_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives CSV lines into the splitter, paces the result side, gives the verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         RANDOM_ITEMS = 600;
	localparam int         PHASES       = 6;
	localparam int         PHASE_ITEMS  = RANDOM_ITEMS / PHASES;
	localparam int         DRAIN_CYCLES = 6;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         STALL_LIMIT  = 5000;
	localparam int         TX_GAP_PCT   = 29;
	localparam int         RX_IDLE_PCT  = 37;
	localparam logic [7:0] DEL_BYTE     = 8'd127;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       s_tvalid  = 1'b0;
	logic [7:0] s_tdata   = 8'd0;
	logic       s_tlast   = 1'b0;
	logic       m_tready  = 1'b0;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	int         fail_count;
	int         pending;
	int         results_seen;
	int         lines_seen;
	int         quote_errors_seen;
	int         bytes_sent;
	int         lines_sent;
	int         stall_cycles;
	bit         no_gaps;
	int         hold_reqs;
	int         holds_done;
	logic [7:0] cur_sep = csvfs_pkg::SEP_RESET;
	logic [7:0] line_buf[$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	csv_line_field_splitter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	csv_split_checker u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tlast           (s_tlast),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.m_tlast           (m_tlast),
		.fail_count        (fail_count),
		.pending           (pending),
		.results_seen      (results_seen),
		.lines_seen        (lines_seen),
		.quote_errors_seen (quote_errors_seen)
	);

	// result side: random backpressure, or one long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != holds_done) begin
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			holds_done++;
		end else begin
			m_tready <= no_gaps || ($urandom_range(99) >= RX_IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		line_buf.insert(line_buf.size(), b);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!no_gaps && $urandom_range(99) < TX_GAP_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (last)
			lines_sent++;
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_byte(line_buf[i], i == line_buf.size() - 1);
	endtask

	// stop offering, wait out every outstanding result, then the pipeline depth
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_sep(input logic [7:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_sep = v;
	endtask

	// field text: mostly printable or high bytes, now and then a control byte
	function automatic logic [7:0] pick_text();
		logic [7:0] b;
		if ($urandom_range(15) == 0)
			return ($urandom_range(32) == 32) ? DEL_BYTE : 8'($urandom_range(31));
		do b = 8'($urandom_range(32, 255));
		while (b == csvfs_pkg::QUOTE_BYTE || b == cur_sep || b == DEL_BYTE);
		return b;
	endfunction

	// a well-formed line of plain and quoted fields, or a line of raw noise
	task automatic build_line();
		int fields;
		line_buf.delete();
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(255)));
			return;
		end
		fields = $urandom_range(1, 4);
		for (int f = 0; f < fields; f++) begin
			if (f > 0)
				add_byte(cur_sep);
			if ($urandom_range(1) == 0) begin
				add_byte(csvfs_pkg::QUOTE_BYTE);
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(5))
					0: add_byte(cur_sep);
					1: begin
						add_byte(csvfs_pkg::QUOTE_BYTE);
						add_byte(csvfs_pkg::QUOTE_BYTE);
					end
					default: add_byte(pick_text());
					endcase
				end
				// leave the quote open once in a while
				if ($urandom_range(9) != 0)
					add_byte(csvfs_pkg::QUOTE_BYTE);
			end else begin
				repeat ($urandom_range(0, 4)) add_byte(pick_text());
			end
		end
		if (line_buf.size() == 0)
			add_byte(pick_text());
	endtask

	initial begin
		logic [7:0] sep_plan [PHASES];
		int         phase_start;
		sep_plan = '{csvfs_pkg::SEP_RESET, 8'hFF, 8'h00, csvfs_pkg::QUOTE_BYTE, 8'h09, 8'h3B};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default separator: text, split, quoted separator, doubled quote, controls, high bytes
		send_byte(8'h41, 1'b0);
		send_byte(csvfs_pkg::SEP_RESET, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(csvfs_pkg::SEP_RESET, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(DEL_BYTE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(csvfs_pkg::SEP_RESET, 1'b1);   // trailing separator closes field and line
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b1);  // lone quote: open at line end
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(8'h7E, 1'b1);                  // content on the last byte, quote still open
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b1);  // doubled quote reopens, line ends inside
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b1);  // empty quoted field
		send_byte(8'h01, 1'b1);                  // control byte as the whole line

		// control byte as separator: splits outside quotes, dropped inside
		write_sep(8'h00);
		send_byte(8'h00, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(8'h00, 1'b1);

		// separator equal to the quote: quoting wins
		write_sep(csvfs_pkg::QUOTE_BYTE);
		send_byte(8'h61, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b0);
		send_byte(csvfs_pkg::QUOTE_BYTE, 1'b1);

		for (int k = 0; k < PHASES; k++) begin
			write_sep(k == PHASES - 1 ? 8'($urandom_range(255)) : sep_plan[k]);
			no_gaps     = (k == 1);
			phase_start = bytes_sent;
			if (k == 2) begin
				// long receiver hold-off while a long line keeps coming
				hold_reqs++;
				line_buf.delete();
				repeat (40) add_byte(pick_text());
				send_line();
			end
			while (bytes_sent - phase_start < PHASE_ITEMS) begin
				if (k == 4 && bytes_sent - phase_start >= PHASE_ITEMS / 2 && pending != 0)
					settle();
				build_line();
				send_line();
			end
		end
		settle();

		$display("tb_top: %0d bytes in %0d lines, separators ',', 0xFF, 0x00, quote, tab, random",
			bytes_sent, lines_sent);
		$display("tb_top: %0d results checked, %0d lines closed, %0d ended inside quotes",
			results_seen, lines_seen, quote_errors_seen);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
